### design/mms_pkg.sv
`default_nettype none
package mms_pkg;

  typedef enum logic [2:0] {
    MODE_MENU     = 3'd0,
    MODE_HELD     = 3'd1,
    MODE_RELEASED = 3'd2,
    MODE_VOLTS    = 3'd3,
    MODE_OHMS     = 3'd4,
    MODE_AMPS     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CFG_CONT_LIMIT = 2'd0,
    CFG_ZERO_CUT   = 2'd1,
    CFG_OPEN_RAW   = 2'd2,
    CFG_REF_OHM    = 2'd3
  } cfg_idx_e;

  localparam int unsigned READ_W       = 22;
  localparam int unsigned CFG_W        = 22;
  localparam logic [READ_W-1:0] READ_MAX = {READ_W{1'b1}};
  localparam logic [7:0]  BTN_SAVE     = 8'h80;
  localparam logic [7:0]  BTN_VOLTS    = 8'h01;
  localparam logic [7:0]  BTN_OHMS     = 8'h02;
  localparam logic [7:0]  BTN_AMPS     = 8'h04;
  localparam logic [4:0]  VOLT_SAMPLES = 5'd30;
  localparam logic [1:0]  CHAN_NONE    = 2'd3;

endpackage
`default_nettype wire

### design/mms_if.sv
`default_nettype none
interface mms_in_if #(parameter int AdcBits = 10);
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         buttons;
  logic [AdcBits-1:0] adc_value;
  modport source (output valid, command, buttons, adc_value, input ready);
  modport sink   (input valid, command, buttons, adc_value, output ready);
endinterface

interface mms_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  mode;
  logic [1:0]                  sample_channel;
  logic                        collecting;
  logic                        reading_valid;
  logic [mms_pkg::READ_W-1:0]  reading;
  logic [mms_pkg::READ_W-1:0]  saved_value;
  logic                        save_done;
  logic                        continuity;
  modport source (output valid, mode, sample_channel, collecting, reading_valid, reading,
                  saved_value, save_done, continuity, input ready);
  modport sink   (input valid, mode, sample_channel, collecting, reading_valid, reading,
                  saved_value, save_done, continuity, output ready);
endinterface

interface mms_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [mms_pkg::CFG_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/multimeter_mode_and_scaling.sv
`default_nettype none
// Channel   Dir  Payload                                        Handshake
// in_i      in   command, buttons, adc_value                    valid/ready
// out_o     out  mode, sample_channel, collecting, reading_valid,
//                reading, saved_value, save_done, continuity    valid/ready
// cfg_i     in   index, data                                    valid/ready (always ready)
//
// A tick, or a sample that does not finish a measurement, goes from accept through the
// S_EMIT state to the result register. A sample that finishes a reading passes S_PREP,
// S_DIV, S_FIN and S_EMIT: the restoring divider retires one quotient bit per cycle
// over the ADC_BITS + 26 bit numerator. One item is in work at a time; the result
// register lets the next item in while the last result waits. Reset is async, active
// low, and clears mode, collection, readings, saved readings and registers to defaults.
module multimeter_mode_and_scaling #(
  parameter int ADC_BITS = 10
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  mms_in_if.sink    in_i,
  mms_out_if.source out_o,
  mms_cfg_if.sink   cfg_i
);

  localparam int FULL  = (1 << ADC_BITS) - 1;
  localparam int SUM_W = ADC_BITS + 5;
  localparam int NUM_W = ADC_BITS + 26;
  localparam int DEN_W = ADC_BITS + 8;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int RW    = mms_pkg::READ_W;

  localparam logic [NUM_W-1:0] VOLT_MUL = NUM_W'(25100);
  localparam logic [NUM_W-1:0] AMP_MUL  = NUM_W'(50200000);
  localparam logic [NUM_W-1:0] AMP_OFF  = NUM_W'(57 * FULL);
  localparam logic [DEN_W-1:0] VOLT_DEN = DEN_W'(30 * FULL);
  localparam logic [DEN_W-1:0] AMP_DEN  = DEN_W'(210 * FULL);
  localparam logic [ADC_BITS-1:0] FULL_CODE = {ADC_BITS{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_DIV, S_FIN, S_EMIT} state_e;

  // configuration
  logic [21:0] cont_limit_q;
  logic [14:0] zero_cut_q;
  logic [9:0]  open_raw_q;
  logic [15:0] ref_ohm_q;

  state_e                 state_q;
  mms_pkg::mode_e         mode_q;
  logic [7:0]             chosen_q;
  logic [4:0]             taken_q;
  logic                   discard_q;
  logic [SUM_W-1:0]       sum_q;
  logic [RW-1:0]          last_q [3];
  logic [RW-1:0]          saved_q [3];
  logic                   tone_q;
  logic                   rvalid_q;
  logic                   saveflag_q;

  // divider
  logic [SUM_W-1:0]       op_q;
  logic [NUM_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W-1:0]       rem_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   neg_q;

  logic                   in_acc;
  logic                   meter;
  logic [1:0]             midx;
  logic [ADC_BITS-1:0]    raw;
  logic [SUM_W-1:0]       sum_nx;
  logic [4:0]             taken_nx;
  logic [DEN_W:0]         trial;
  logic                   qbit;
  logic [NUM_W-1:0]       prod;
  logic [RW-1:0]          qsat;
  logic [RW-1:0]          val;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign raw         = in_i.adc_value;
  assign meter       = (mode_q == mms_pkg::MODE_VOLTS) || (mode_q == mms_pkg::MODE_OHMS) ||
                       (mode_q == mms_pkg::MODE_AMPS);
  assign midx        = 2'(mode_q - mms_pkg::MODE_VOLTS);
  assign sum_nx      = sum_q + SUM_W'(raw);
  assign taken_nx    = taken_q + 5'd1;

  // one restoring step a cycle
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    case (mode_q)
      mms_pkg::MODE_VOLTS: prod = NUM_W'(op_q) * VOLT_MUL;
      mms_pkg::MODE_OHMS:  prod = NUM_W'(op_q[ADC_BITS-1:0]) * NUM_W'(ref_ohm_q);
      default:             prod = NUM_W'(op_q) * AMP_MUL;
    endcase
  end

  assign qsat = (|num_q[NUM_W-1:RW]) ? mms_pkg::READ_MAX : num_q[RW-1:0];

  always_comb begin
    case (mode_q)
      mms_pkg::MODE_VOLTS: val = (qsat < RW'(zero_cut_q)) ? '0 : qsat;
      mms_pkg::MODE_OHMS: begin
        if (op_q[ADC_BITS-1:0] > ADC_BITS'(open_raw_q)) begin
          val = '0;
        end else if (op_q[ADC_BITS-1:0] == FULL_CODE) begin
          val = mms_pkg::READ_MAX;
        end else begin
          val = qsat;
        end
      end
      default: val = neg_q ? '0 : qsat;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_limit_q <= 22'd500;
      zero_cut_q   <= 15'd20;
      open_raw_q   <= 10'd1021;
      ref_ohm_q    <= 16'd4680;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mms_pkg::CFG_CONT_LIMIT: cont_limit_q <= cfg_i.data;
        mms_pkg::CFG_ZERO_CUT:   zero_cut_q   <= cfg_i.data[14:0];
        mms_pkg::CFG_OPEN_RAW:   open_raw_q   <= cfg_i.data[9:0];
        mms_pkg::CFG_REF_OHM:    ref_ohm_q    <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: op_q <= (mode_q == mms_pkg::MODE_VOLTS) ? sum_nx : SUM_W'(raw);
      S_PREP: begin
        rem_q <= '0;
        cnt_q <= CNT_W'(NUM_W);
        neg_q <= 1'b0;
        case (mode_q)
          mms_pkg::MODE_VOLTS: begin
            num_q <= prod;
            den_q <= VOLT_DEN;
          end
          mms_pkg::MODE_OHMS: begin
            num_q <= prod;
            den_q <= DEN_W'(FULL_CODE - op_q[ADC_BITS-1:0]);
          end
          default: begin
            neg_q <= (prod < AMP_OFF);
            num_q <= prod - AMP_OFF;
            den_q <= AMP_DEN;
          end
        endcase
      end
      S_DIV: begin
        num_q <= {num_q[NUM_W-2:0], qbit};
        rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        cnt_q <= cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= mms_pkg::MODE_MENU;
      chosen_q   <= '0;
      taken_q    <= '0;
      discard_q  <= 1'b0;
      sum_q      <= '0;
      last_q     <= '{default: '0};
      saved_q    <= '{default: '0};
      tone_q     <= 1'b0;
      rvalid_q   <= 1'b0;
      saveflag_q <= 1'b0;
      out_o.valid          <= 1'b0;
      out_o.mode           <= '0;
      out_o.sample_channel <= '0;
      out_o.collecting     <= 1'b0;
      out_o.reading_valid  <= 1'b0;
      out_o.reading        <= '0;
      out_o.saved_value    <= '0;
      out_o.save_done      <= 1'b0;
      out_o.continuity     <= 1'b0;
    end else begin
      // in S_EMIT the reload below decides valid
      if (out_o.valid && out_o.ready && state_q != S_EMIT) begin
        out_o.valid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            rvalid_q   <= 1'b0;
            saveflag_q <= 1'b0;
            state_q    <= S_EMIT;
            if (!in_i.command) begin
              // tick: menu walk
              case (mode_q)
                mms_pkg::MODE_HELD: begin
                  if (in_i.buttons == '0) mode_q <= mms_pkg::MODE_RELEASED;
                end
                mms_pkg::MODE_RELEASED: begin
                  discard_q <= 1'b1;
                  taken_q   <= '0;
                  sum_q     <= '0;
                  tone_q    <= 1'b0;
                  case (chosen_q)
                    mms_pkg::BTN_VOLTS: mode_q <= mms_pkg::MODE_VOLTS;
                    mms_pkg::BTN_OHMS:  mode_q <= mms_pkg::MODE_OHMS;
                    mms_pkg::BTN_AMPS:  mode_q <= mms_pkg::MODE_AMPS;
                    default: begin
                      mode_q    <= mms_pkg::MODE_MENU;
                      discard_q <= 1'b0;
                    end
                  endcase
                end
                mms_pkg::MODE_VOLTS, mms_pkg::MODE_OHMS, mms_pkg::MODE_AMPS: begin
                  if (in_i.buttons == mms_pkg::BTN_SAVE) begin
                    saved_q[midx] <= last_q[midx];
                    saveflag_q    <= 1'b1;
                  end else if (in_i.buttons != '0) begin
                    chosen_q  <= in_i.buttons;
                    mode_q    <= mms_pkg::MODE_HELD;
                    discard_q <= 1'b0;
                    taken_q   <= '0;
                    sum_q     <= '0;
                    tone_q    <= 1'b0;
                  end
                end
                default: begin
                  // menu, and the unused codes
                  mode_q <= mms_pkg::MODE_MENU;
                  if (in_i.buttons == mms_pkg::BTN_VOLTS ||
                      in_i.buttons == mms_pkg::BTN_OHMS ||
                      in_i.buttons == mms_pkg::BTN_AMPS) begin
                    chosen_q <= in_i.buttons;
                    mode_q   <= mms_pkg::MODE_HELD;
                  end
                end
              endcase
            end else if (meter) begin
              if (discard_q) begin
                discard_q <= 1'b0;
              end else if (mode_q == mms_pkg::MODE_VOLTS && taken_nx < mms_pkg::VOLT_SAMPLES) begin
                sum_q   <= sum_nx;
                taken_q <= taken_nx;
              end else begin
                state_q <= S_PREP;
              end
            end
          end
        end
        S_PREP: state_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == CNT_W'(1)) state_q <= S_FIN;
        end
        S_FIN: begin
          last_q[midx] <= val;
          if (mode_q == mms_pkg::MODE_OHMS) begin
            tone_q <= (val != '0) && (val < cont_limit_q);
          end
          discard_q <= 1'b1;
          taken_q   <= '0;
          sum_q     <= '0;
          rvalid_q  <= 1'b1;
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_o.valid || out_o.ready) begin
            out_o.valid          <= 1'b1;
            out_o.mode           <= mode_q;
            out_o.sample_channel <= meter ? midx : mms_pkg::CHAN_NONE;
            out_o.collecting     <= meter;
            out_o.reading_valid  <= rvalid_q;
            out_o.reading        <= meter ? last_q[midx] : '0;
            out_o.saved_value    <= meter ? saved_q[midx] : '0;
            out_o.save_done      <= saveflag_q;
            out_o.continuity     <= tone_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/mms_checker.sv
`default_nettype none
module mms_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] mode,
  input wire [1:0] sample_channel,
  input wire       collecting,
  input wire       reading_valid,
  input wire       save_done,
  input wire       continuity
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_collect_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (collecting == (sample_channel != mms_pkg::CHAN_NONE)))
    else $error("collecting disagrees with channel");

  a_read_meter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && reading_valid |-> collecting && !save_done)
    else $error("reading outside a meter sample");

  a_tone_ohms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && continuity |-> (mode == mms_pkg::MODE_OHMS))
    else $error("tone outside ohm mode");

endmodule

bind multimeter_mode_and_scaling mms_checker u_mms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .mode           (out_o.mode),
  .sample_channel (out_o.sample_channel),
  .collecting     (out_o.collecting),
  .reading_valid  (out_o.reading_valid),
  .save_done      (out_o.save_done),
  .continuity     (out_o.continuity)
);
`default_nettype wire

### tb/mms_tb_if.sv
`timescale 1ns / 100ps
// Channel interfaces are those of the design; this file only holds the bench clock generator.
module mms_tb_clkgen (
  output logic clk_o
);
  initial clk_o = 1'b0;
  always begin
    #5 clk_o = 1'b1;
    #5 clk_o = 1'b0;
  end
endmodule

### tb/multimeter_mode_and_scaling_tb.sv
`timescale 1ns / 100ps
// Bench for the meter front end: ticks and ADC samples go in over a valid/ready
// channel, one result comes back per item and is compared field by field with
// a behavioral predictor of the mode machine and the scaling math.
module multimeter_mode_and_scaling_tb;

  localparam int unsigned FULL = 1023;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  chan;
    logic        coll;
    logic        rvalid;
    logic [21:0] reading;
    logic [21:0] saved;
    logic        save_done;
    logic        cont;
  } meter_res_t;

  typedef struct {
    logic       cmd;
    logic [7:0] btn;
    logic [9:0] adc;
    logic       fixed;   // expected result typed in below
    meter_res_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mms_tb_clkgen i_clk (.clk_o(clk_i));

  mms_in_if  #(.AdcBits(10)) in_ch ();
  mms_out_if                 out_ch ();
  mms_cfg_if                 cfg_ch ();

  multimeter_mode_and_scaling #(.ADC_BITS(10)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // predictor state
  logic [21:0]     p_cont_limit;
  logic [14:0]     p_zero_cut;
  logic [9:0]      p_open_raw;
  logic [15:0]     p_ref;
  mms_pkg::mode_e  p_mode;
  logic [7:0]      p_choice;
  int unsigned     p_taken;
  logic            p_discard;
  int unsigned     p_sum;
  logic [21:0]     p_last [3];
  logic [21:0]     p_saved [3];
  logic            p_tone;

  meter_res_t  expected_q [$];
  int          fail_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;
  longint      cycle_cnt;

  function automatic logic [21:0] clip22(longint unsigned v);
    return (v > 64'h3FFFFF) ? 22'h3FFFFF : v[21:0];
  endfunction

  function automatic bit meter_mode(mms_pkg::mode_e m);
    return m == mms_pkg::MODE_VOLTS || m == mms_pkg::MODE_OHMS || m == mms_pkg::MODE_AMPS;
  endfunction

  task automatic meter_reset();
    p_cont_limit = 22'd500;
    p_zero_cut   = 15'd20;
    p_open_raw   = 10'd1021;
    p_ref        = 16'd4680;
    p_mode       = mms_pkg::MODE_MENU;
    p_choice     = '0;
    p_taken      = 0;
    p_discard    = 1'b0;
    p_sum        = 0;
    p_tone       = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p_last[i]  = '0;
      p_saved[i] = '0;
    end
  endtask

  // Advance the meter model by one item and return the result it should give.
  function automatic meter_res_t meter_predict(logic cmd, logic [7:0] btn, logic [9:0] adc);
    meter_res_t r;
    logic [21:0] val;
    longint unsigned num;
    int unsigned need;
    int k;
    r = '0;
    if (!cmd) begin
      case (p_mode)
        mms_pkg::MODE_MENU: begin
          if (btn == mms_pkg::BTN_VOLTS || btn == mms_pkg::BTN_OHMS ||
              btn == mms_pkg::BTN_AMPS) begin
            p_choice = btn;
            p_mode = mms_pkg::MODE_HELD;
          end
        end
        mms_pkg::MODE_HELD: if (btn == 8'h00) p_mode = mms_pkg::MODE_RELEASED;
        mms_pkg::MODE_RELEASED: begin
          if (p_choice == mms_pkg::BTN_VOLTS) p_mode = mms_pkg::MODE_VOLTS;
          else if (p_choice == mms_pkg::BTN_OHMS) p_mode = mms_pkg::MODE_OHMS;
          else if (p_choice == mms_pkg::BTN_AMPS) p_mode = mms_pkg::MODE_AMPS;
          else p_mode = mms_pkg::MODE_MENU;
          if (meter_mode(p_mode)) begin
            p_discard = 1'b1; p_taken = 0; p_sum = 0;
          end
        end
        default: begin
          k = int'(p_mode) - int'(mms_pkg::MODE_VOLTS);
          if (btn == mms_pkg::BTN_SAVE) begin
            p_saved[k] = p_last[k];
            r.save_done = 1'b1;
          end else if (btn != 8'h00) begin
            p_choice = btn;
            p_mode = mms_pkg::MODE_HELD;
            p_discard = 1'b0; p_taken = 0; p_sum = 0;
          end
        end
      endcase
    end else if (meter_mode(p_mode)) begin
      if (p_discard) begin
        p_discard = 1'b0;
      end else begin
        p_sum += adc;
        p_taken++;
        need = (p_mode == mms_pkg::MODE_VOLTS) ? 30 : 1;
        if (p_taken >= need) begin
          k = int'(p_mode) - int'(mms_pkg::MODE_VOLTS);
          if (p_mode == mms_pkg::MODE_VOLTS) begin
            num = (longint'(p_sum) * 25100) / (30 * FULL);
            val = (num < p_zero_cut) ? 22'd0 : clip22(num);
          end else if (p_mode == mms_pkg::MODE_OHMS) begin
            if (adc > p_open_raw) val = '0;
            else if (adc >= FULL) val = 22'h3FFFFF;
            else val = clip22((longint'(p_ref) * adc) / (FULL - adc));
            p_tone = (val > 0 && val < p_cont_limit);
          end else begin
            num = longint'(adc) * 50200000;
            if (num < 57 * FULL) val = '0;
            else val = clip22((num - 57 * FULL) / (210 * FULL));
          end
          p_last[k] = val;
          p_discard = 1'b1; p_taken = 0; p_sum = 0;
          r.rvalid = 1'b1;
        end
      end
    end
    if (p_mode != mms_pkg::MODE_OHMS) p_tone = 1'b0;
    r.mode = p_mode;
    if (meter_mode(p_mode)) begin
      k = int'(p_mode) - int'(mms_pkg::MODE_VOLTS);
      r.chan = k[1:0];
      r.coll = 1'b1;
      r.reading = p_last[k];
      r.saved = p_saved[k];
    end else begin
      r.chan = mms_pkg::CHAN_NONE;
    end
    r.cont = p_tone;
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_item(logic cmd, logic [7:0] btn, logic [9:0] adc);
    meter_res_t e;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.buttons   <= btn;
    in_ch.adc_value <= adc;
    e = meter_predict(cmd, btn, adc);
    expected_q.push_back(e);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    in_ch.valid <= 1'b0;
    // the block is busy for at least this cycle after an accept
    @(posedge clk_i);
  endtask

  task automatic send_row(stim_row_t row);
    meter_res_t e;
    send_item(row.cmd, row.btn, row.adc);
    // a typed row must agree with the predictor's own answer
    if (row.fixed) begin
      e = expected_q[$];
      if (e != row.res) begin
        $error("table row: expected %h, predictor %h", row.res, e);
        fail_cnt++;
      end
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(mms_pkg::cfg_idx_e idx, logic [21:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      mms_pkg::CFG_CONT_LIMIT: p_cont_limit = val;
      mms_pkg::CFG_ZERO_CUT:   p_zero_cut   = val[14:0];
      mms_pkg::CFG_OPEN_RAW:   p_open_raw   = val[9:0];
      default:                 p_ref        = val[15:0];
    endcase
  endtask

  // park in the menu or a meter mode first, then pick the new mode
  task automatic enter_mode(logic [7:0] btn);
    send_item(1'b0, 8'h08, 10'($urandom));
    send_item(1'b0, 8'h00, 10'($urandom));
    send_item(1'b0, 8'h00, 10'($urandom));
    send_item(1'b0, 8'h00, 10'($urandom));
    send_item(1'b0, btn, 10'($urandom));
    send_item(1'b0, 8'h00, 10'($urandom));
    send_item(1'b0, 8'h00, 10'($urandom));
  endtask

  // Mostly well-formed menu traffic and measurements, with some noise.
  task automatic random_items(int n);
    int sel;
    logic [7:0] btn;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        case ($urandom_range(2))
          0: btn = mms_pkg::BTN_VOLTS;
          1: btn = mms_pkg::BTN_OHMS;
          default: btn = mms_pkg::BTN_AMPS;
        endcase
        send_item(1'b0, btn, 10'($urandom));
      end else if (sel < 14) begin
        send_item(1'b0, 8'h00, 10'($urandom));
      end else if (sel < 18) begin
        send_item(1'b0, mms_pkg::BTN_SAVE, 10'($urandom));
      end else if (sel < 21) begin
        send_item(1'b0, 8'($urandom), 10'($urandom));
      end else if (sel < 88) begin
        send_item(1'b1, 8'($urandom), ($urandom_range(3) == 0) ?
                  10'(1023 - $urandom_range(3)) : 10'($urandom));
      end else begin
        send_item(1'b1, 8'($urandom), 10'($urandom_range(40)));
      end
    end
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk_i) begin
    meter_res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.mode !== e.mode) begin
          $error("mode exp %0d got %0d", e.mode, out_ch.mode); fail_cnt++;
        end
        if (out_ch.sample_channel !== e.chan) begin
          $error("sample_channel exp %0d got %0d", e.chan, out_ch.sample_channel); fail_cnt++;
        end
        if (out_ch.collecting !== e.coll) begin
          $error("collecting exp %0d got %0d", e.coll, out_ch.collecting); fail_cnt++;
        end
        if (out_ch.reading_valid !== e.rvalid) begin
          $error("reading_valid exp %0d got %0d", e.rvalid, out_ch.reading_valid);
          fail_cnt++;
        end
        if (out_ch.reading !== e.reading) begin
          $error("reading exp %0d got %0d", e.reading, out_ch.reading); fail_cnt++;
        end
        if (out_ch.saved_value !== e.saved) begin
          $error("saved_value exp %0d got %0d", e.saved, out_ch.saved_value); fail_cnt++;
        end
        if (out_ch.save_done !== e.save_done) begin
          $error("save_done exp %0d got %0d", e.save_done, out_ch.save_done); fail_cnt++;
        end
        if (out_ch.continuity !== e.cont) begin
          $error("continuity exp %0d got %0d", e.cont, out_ch.continuity); fail_cnt++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off while recv_hold is set
  always @(posedge clk_i) begin
    if (recv_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  stim_row_t dir_tbl [$];

  function automatic stim_row_t row(logic cmd, logic [7:0] btn, logic [9:0] adc);
    stim_row_t r;
    r.cmd = cmd; r.btn = btn; r.adc = adc; r.fixed = 1'b0; r.res = '0;
    return r;
  endfunction

  function automatic stim_row_t row_fixed(logic cmd, logic [7:0] btn, logic [9:0] adc,
                                          meter_res_t res);
    stim_row_t r;
    r = row(cmd, btn, adc);
    r.fixed = 1'b1;
    r.res = res;
    return r;
  endfunction

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = 1'b0;
    in_ch.buttons   = '0;
    in_ch.adc_value = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = mms_pkg::CFG_CONT_LIMIT;
    cfg_ch.data     = '0;
    recv_hold       = 1'b0;
    cycle_cnt       = 0;
    fail_cnt        = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    meter_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Fixed rows: sample in menu is ignored, menu extremes,
    // unknown choice falls back to menu, ohm open circuit at full scale.
    dir_tbl.push_back(row_fixed(1'b1, 8'hFF, 10'h3FF,
      '{mode: mms_pkg::MODE_MENU, chan: mms_pkg::CHAN_NONE, default: '0}));
    dir_tbl.push_back(row_fixed(1'b0, 8'hFF, 10'h000,
      '{mode: mms_pkg::MODE_MENU, chan: mms_pkg::CHAN_NONE, default: '0}));
    dir_tbl.push_back(row(1'b0, mms_pkg::BTN_OHMS, 10'h3FF));
    dir_tbl.push_back(row(1'b0, 8'h00, 10'h000));
    dir_tbl.push_back(row(1'b0, 8'h00, 10'h000));
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd500));    // discard sample
    dir_tbl.push_back(row_fixed(1'b1, 8'h00, 10'd1023,   // open circuit, reads 0
      '{mode: mms_pkg::MODE_OHMS, chan: 2'd1, coll: 1'b1, rvalid: 1'b1, default: '0}));
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd1022));    // discard
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd50));      // continuity on
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd0));       // discard
    dir_tbl.push_back(row(1'b0, mms_pkg::BTN_SAVE, 10'd0));
    dir_tbl.push_back(row(1'b0, 8'h03, 10'd0));       // unknown choice held
    dir_tbl.push_back(row(1'b0, 8'h03, 10'd0));
    dir_tbl.push_back(row(1'b0, 8'h00, 10'd0));
    dir_tbl.push_back(row_fixed(1'b0, 8'h00, 10'd0,
      '{mode: mms_pkg::MODE_MENU, chan: mms_pkg::CHAN_NONE, default: '0}));
    dir_tbl.push_back(row(1'b0, mms_pkg::BTN_AMPS, 10'd0));
    dir_tbl.push_back(row(1'b0, 8'h00, 10'd0));
    dir_tbl.push_back(row(1'b0, 8'h00, 10'd0));
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd0));
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd0));        // below offset, 0 uA
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd0));
    dir_tbl.push_back(row(1'b1, 8'h00, 10'd1023));     // full scale current
    dir_tbl.push_back(row(1'b0, mms_pkg::BTN_SAVE, 10'd0));
    foreach (dir_tbl[i]) send_row(dir_tbl[i]);

    // full volt measurement at full scale
    enter_mode(mms_pkg::BTN_VOLTS);
    for (int i = 0; i < 31; i++) send_item(1'b1, 8'h00, 10'd1023);
    send_item(1'b0, mms_pkg::BTN_SAVE, 10'd0);
    drain();

    // phase 1: reset-value registers, sender 16 / receiver 74
    send_idle_pct = 16; recv_idle_pct = 74;
    random_items(250);
    drain();

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      random_items(20);
    join
    drain();

    // extremes: large limits, open limit at 1022 so saturation is reachable
    write_reg(mms_pkg::CFG_CONT_LIMIT, 22'd2389140);
    write_reg(mms_pkg::CFG_ZERO_CUT, 22'd25100);
    write_reg(mms_pkg::CFG_OPEN_RAW, 22'd1022);
    write_reg(mms_pkg::CFG_REF_OHM, 22'd65535);
    send_idle_pct = 74; recv_idle_pct = 16;
    enter_mode(mms_pkg::BTN_OHMS);
    send_item(1'b1, 8'h00, 10'd0);
    send_item(1'b1, 8'h00, 10'd1022);    // saturates
    random_items(250);
    drain();

    // other extreme: zero limits, reference at 1
    write_reg(mms_pkg::CFG_CONT_LIMIT, 22'd0);
    write_reg(mms_pkg::CFG_ZERO_CUT, 22'd0);
    write_reg(mms_pkg::CFG_OPEN_RAW, 22'd0);
    write_reg(mms_pkg::CFG_REF_OHM, 22'd1);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(150);
    drain();

    // random midrange settings
    write_reg(mms_pkg::CFG_CONT_LIMIT, 22'($urandom_range(20000)));
    write_reg(mms_pkg::CFG_ZERO_CUT, 22'($urandom_range(3000)));
    write_reg(mms_pkg::CFG_OPEN_RAW, 22'($urandom_range(1022, 900)));
    write_reg(mms_pkg::CFG_REF_OHM, 22'($urandom_range(65535, 1)));
    random_items(200);
    drain();

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
